>>> rtl/lbsa_pkg.sv
// Shared types, constants and the band-bound table builder for the
// log-band spectrum averager. No dependencies.
package lbsa_pkg;

    localparam int unsigned FFT_SIZE_DEF   = 1024;
    localparam int unsigned BAND_STEPS_DEF = 256;
    localparam int unsigned BAND_MAX       = 256;
    localparam int unsigned BOUND_W        = 24;
    localparam int unsigned TOTAL_W        = 9;
    localparam int unsigned ROM_BITS       = BAND_MAX * BOUND_W + TOTAL_W;
    localparam int unsigned MAX_RES        = 64;
    // wide enough for (N/2 + 1) ^ BAND_STEPS at the largest sizes
    localparam int unsigned POW_W          = 3104;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_BAND,
        ST_MULT,
        ST_SAT,
        ST_DIV,
        ST_PUSH,
        ST_FLUSH
    } lbsa_state_t;

    typedef enum logic [1:0] {
        MG_IDLE,
        MG_SQUARE,
        MG_ROOT
    } lbsa_mag_state_t;

    // exact integer power, evaluated at elaboration only
    function automatic logic [POW_W-1:0] int_pow(int unsigned b, int unsigned e);
        logic [POW_W-1:0] p;
        logic [POW_W-1:0] base;
        int unsigned rest;
        p    = POW_W'(1);
        base = POW_W'(b);
        rest = e;
        while (rest != 0)
        begin
            if (rest[0])
                p = p * base;
            base = base * base;
            rest = rest >> 1;
        end
        return p;
    endfunction

    // Band table: low bin in 11..0, high bin in 23..12 per band, band count on top.
    // Band k runs from floor(M^(k/S)) to ceil(M^((k+1)/S)) - 1, M = N/2.
    function automatic logic [ROM_BITS-1:0] build_band_rom(int unsigned pt_count,
                                                           int unsigned steps);
        int unsigned half;
        int unsigned mexp;
        int unsigned b;
        int unsigned lo;
        int unsigned hi;
        int unsigned total;
        int unsigned rf [0:BAND_MAX];
        logic        rx [0:BAND_MAX];
        logic [POW_W-1:0] lim;
        logic [ROM_BITS-1:0] img;
        logic stop;
        half  = pt_count >> 1;
        mexp  = $clog2(half);
        b     = 1;
        img   = '0;
        total = 0;
        stop  = 1'b0;
        for (int unsigned k = 0; k <= steps; k++)
        begin
            lim = '0;
            lim[mexp * k] = 1'b1;
            while (int_pow(b + 1, steps) <= lim)
                b++;
            rf[k] = b;
            rx[k] = (int_pow(b, steps) == lim);
        end
        for (int unsigned k = 0; k < steps; k++)
        begin
            if (!stop)
            begin
                if (rf[k + 1] >= half - 1)
                    stop = 1'b1;
                else
                begin
                    lo = rf[k];
                    hi = rx[k + 1] ? rf[k + 1] - 1 : rf[k + 1];
                    img[k * BOUND_W +: BOUND_W] = {12'(hi), 12'(lo)};
                    total = k + 1;
                end
            end
        end
        img[ROM_BITS-1 -: TOTAL_W] = TOTAL_W'(total);
        return img;
    endfunction

endpackage

>>> rtl/lbsa_chan_if.sv
// Valid/ready channel interfaces for bins in and band results out.
// Depends on nothing.
interface lbsa_bin_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] bin_real;
    logic signed [31:0] bin_imag;
    logic               frame_start;

    modport source (output valid, bin_real, bin_imag, frame_start, input ready);
    modport sink   (input valid, bin_real, bin_imag, frame_start, output ready);
endinterface

interface lbsa_band_if;
    logic        valid;
    logic        ready;
    logic [7:0]  band_number;
    logic [11:0] bar_height;
    logic        final_band;
    logic        run_end;

    modport source (output valid, band_number, bar_height, final_band, run_end,
                    input ready);
    modport sink   (input valid, band_number, bar_height, final_band, run_end,
                    output ready);
endinterface

>>> rtl/lbsa_mag_unit.sv
// Bit-serial magnitude: shift-add re^2 + im^2, then digit-by-digit square root,
// then shift by log2(FFT size). Depends on lbsa_pkg.
module lbsa_mag_unit #(
    parameter int unsigned MAG_SHIFT = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] bin_real,
    input  logic signed [31:0] bin_imag,
    output logic               done,
    output logic [31:0]        mag
);
    import lbsa_pkg::*;

    lbsa_mag_state_t state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [63:0] mcand_re_reg, mcand_re_next;
    logic [63:0] mcand_im_reg, mcand_im_next;
    logic [31:0] mplr_re_reg, mplr_re_next;
    logic [31:0] mplr_im_reg, mplr_im_next;
    logic [63:0] acc_reg, acc_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic        done_reg, done_next;

    logic [31:0] abs_re, abs_im;
    logic [35:0] rem_sh, trial;

    assign abs_re = bin_real[31] ? 32'(-bin_real) : 32'(bin_real);
    assign abs_im = bin_imag[31] ? 32'(-bin_imag) : 32'(bin_imag);
    assign rem_sh = {rem_reg[33:0], acc_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MG_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mcand_re_reg <= mcand_re_next;
        mcand_im_reg <= mcand_im_next;
        mplr_re_reg  <= mplr_re_next;
        mplr_im_reg  <= mplr_im_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
    end

    // sequencer: 32 square steps, then 32 root steps
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        done_next     = 1'b0;
        mcand_re_next = mcand_re_reg;
        mcand_im_next = mcand_im_reg;
        mplr_re_next  = mplr_re_reg;
        mplr_im_next  = mplr_im_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        case (state_reg)
            MG_IDLE:
            begin
                if (start)
                begin
                    mcand_re_next = {32'd0, abs_re};
                    mcand_im_next = {32'd0, abs_im};
                    mplr_re_next  = abs_re;
                    mplr_im_next  = abs_im;
                    acc_next      = '0;
                    step_next     = '0;
                    state_next    = MG_SQUARE;
                end
            end
            MG_SQUARE:
            begin
                acc_next = acc_reg + (mplr_re_reg[0] ? mcand_re_reg : 64'd0)
                                   + (mplr_im_reg[0] ? mcand_im_reg : 64'd0);
                mcand_re_next = {mcand_re_reg[62:0], 1'b0};
                mcand_im_next = {mcand_im_reg[62:0], 1'b0};
                mplr_re_next  = {1'b0, mplr_re_reg[31:1]};
                mplr_im_next  = {1'b0, mplr_im_reg[31:1]};
                step_next     = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = MG_ROOT;
                end
            end
            MG_ROOT:
            begin
                acc_next  = {acc_reg[61:0], 2'b00};
                step_next = step_reg + 5'd1;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[30:0], 1'b0};
                end
                if (step_reg == 5'd31)
                begin
                    done_next  = 1'b1;
                    state_next = MG_IDLE;
                end
            end
            default:
            begin
                state_next = MG_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign mag  = root_reg >> MAG_SHIFT;

endmodule

>>> rtl/log_band_spectrum_averager_unit.sv
// Top level of the log-band spectrum averager: band bookkeeping, serial divide
// and result staging. Depends on lbsa_pkg, lbsa_chan_if and lbsa_mag_unit.
//
//   channel  | dir | payload
//   bin_ch   | in  | bin_real, bin_imag, frame_start
//   band_ch  | out | band_number, bar_height, final_band, run_end
//
// A bin first waits on the magnitude unit (start, 32 square and 32 root
// steps), then takes one band test for each band it reaches and, per closed
// band, a multiply, a range check, 12 divide steps and staging (no divide
// when saturated), then a flush if any band closed, then returns to idle.
// Reset clears all counters; the band table is constant, no clearing pass.
// A stalled output holds the sequencer at the next result; bins wait in turn.
module log_band_spectrum_averager_unit #(
    parameter int unsigned FFT_SIZE   = lbsa_pkg::FFT_SIZE_DEF,
    parameter int unsigned BAND_STEPS = lbsa_pkg::BAND_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lbsa_bin_if.sink    bin_ch,
    lbsa_band_if.source band_ch
);
    import lbsa_pkg::*;

    localparam logic [ROM_BITS-1:0] ROM_IMG = build_band_rom(FFT_SIZE, BAND_STEPS);
    localparam logic [TOTAL_W-1:0]  BAND_TOTAL = ROM_IMG[ROM_BITS-1 -: TOTAL_W];
    localparam int unsigned         MAG_SHIFT = $clog2(FFT_SIZE);

    lbsa_state_t state_reg, state_next;
    logic [11:0] bin_cnt_reg, bin_cnt_next;
    logic [11:0] cur_bin_reg, cur_bin_next;
    logic [8:0]  open_band_reg, open_band_next;
    logic [31:0] sum_reg, sum_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [6:0]  nres_reg, nres_next;
    logic [27:0] div_rem_reg, div_rem_next;
    logic [22:0] div_d_reg, div_d_next;
    logic [11:0] quo_reg, quo_next;
    logic [3:0]  div_step_reg, div_step_next;
    logic        held_valid_reg, held_valid_next;
    logic [7:0]  held_band_reg, held_band_next;
    logic [11:0] held_bar_reg, held_bar_next;
    logic        held_final_reg, held_final_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_band_reg, out_band_next;
    logic [11:0] out_bar_reg, out_bar_next;
    logic        out_final_reg, out_final_next;
    logic        out_end_reg, out_end_next;

    logic        mag_start, mag_done;
    logic [31:0] mag;
    logic [23:0] bound;
    logic [11:0] lo_bin, hi_bin;
    logic [32:0] sum_add;
    logic [42:0] scaled;
    logic        slot_free;
    logic        accept;

    lbsa_mag_unit #(
        .MAG_SHIFT (MAG_SHIFT)
    ) u_mag (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mag_start),
        .bin_real (bin_ch.bin_real),
        .bin_imag (bin_ch.bin_imag),
        .done     (mag_done),
        .mag      (mag)
    );

    assign accept    = bin_ch.valid && bin_ch.ready;
    assign mag_start = accept;
    assign bound     = ROM_IMG[13'(open_band_reg[7:0]) * 13'd24 +: BOUND_W];
    assign lo_bin    = bound[11:0];
    assign hi_bin    = bound[23:12];
    assign sum_add   = {1'b0, sum_reg} + {1'b0, mag};
    assign scaled    = 43'(sum_reg) * 43'd2000;
    assign slot_free = !out_valid_reg || band_ch.ready;

    assign bin_ch.ready        = (state_reg == ST_IDLE);
    assign band_ch.valid       = out_valid_reg;
    assign band_ch.band_number = out_band_reg;
    assign band_ch.bar_height  = out_bar_reg;
    assign band_ch.final_band  = out_final_reg;
    assign band_ch.run_end     = out_end_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bin_cnt_reg    <= '0;
            open_band_reg  <= '0;
            sum_reg        <= '0;
            cnt_reg        <= '0;
            nres_reg       <= '0;
            div_step_reg   <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bin_cnt_reg    <= bin_cnt_next;
            open_band_reg  <= open_band_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            nres_reg       <= nres_next;
            div_step_reg   <= div_step_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_bin_reg    <= cur_bin_next;
        div_rem_reg    <= div_rem_next;
        div_d_reg      <= div_d_next;
        quo_reg        <= quo_next;
        held_band_reg  <= held_band_next;
        held_bar_reg   <= held_bar_next;
        held_final_reg <= held_final_next;
        out_band_reg   <= out_band_next;
        out_bar_reg    <= out_bar_next;
        out_final_reg  <= out_final_next;
        out_end_reg    <= out_end_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        bin_cnt_next    = bin_cnt_reg;
        cur_bin_next    = cur_bin_reg;
        open_band_next  = open_band_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        nres_next       = nres_reg;
        div_rem_next    = div_rem_reg;
        div_d_next      = div_d_reg;
        quo_next        = quo_reg;
        div_step_next   = div_step_reg;
        held_valid_next = held_valid_reg;
        held_band_next  = held_band_reg;
        held_bar_next   = held_bar_reg;
        held_final_next = held_final_reg;
        out_valid_next  = out_valid_reg && !band_ch.ready;
        out_band_next   = out_band_reg;
        out_bar_next    = out_bar_reg;
        out_final_next  = out_final_reg;
        out_end_next    = out_end_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bin_ch.frame_start)
                    begin
                        cur_bin_next   = '0;
                        bin_cnt_next   = 12'd1;
                        open_band_next = '0;
                        sum_next       = '0;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        cur_bin_next = bin_cnt_reg;
                        if (bin_cnt_reg != 12'hFFF)
                            bin_cnt_next = bin_cnt_reg + 12'd1;
                    end
                    nres_next  = '0;
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (mag_done)
                    state_next = ST_BAND;
            end
            // one band test per cycle; a closed band goes to the divider
            ST_BAND:
            begin
                if (open_band_reg < BAND_TOTAL && nres_reg < 7'(MAX_RES)
                    && cur_bin_reg >= lo_bin)
                begin
                    sum_next = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                    if (cnt_reg != 12'hFFF)
                        cnt_next = cnt_reg + 12'd1;
                    if (cur_bin_reg < hi_bin)
                        state_next = held_valid_reg ? ST_FLUSH : ST_IDLE;
                    else
                        state_next = ST_MULT;
                end
                else
                begin
                    state_next = held_valid_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            // sum * 2000 / 2^15, kept for the divide
            ST_MULT:
            begin
                div_rem_next = scaled[42:15];
                state_next   = ST_SAT;
            end
            ST_SAT:
            begin
                quo_next = '0;
                if (div_rem_reg >= {4'd0, cnt_reg, 12'd0})
                begin
                    quo_next   = 12'hFFF;
                    state_next = ST_PUSH;
                end
                else
                begin
                    div_d_next    = {cnt_reg, 11'd0};
                    div_step_next = 4'd11;
                    state_next    = ST_DIV;
                end
            end
            // restoring divide, one quotient bit a cycle
            ST_DIV:
            begin
                if (div_rem_reg >= {5'd0, div_d_reg})
                begin
                    div_rem_next = div_rem_reg - {5'd0, div_d_reg};
                    quo_next     = {quo_reg[10:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[10:0], 1'b0};
                end
                div_d_next    = {1'b0, div_d_reg[22:1]};
                div_step_next = div_step_reg - 4'd1;
                if (div_step_reg == 4'd0)
                    state_next = ST_PUSH;
            end
            // older staged result leaves; this one waits to learn if it ends the run
            ST_PUSH:
            begin
                if (!held_valid_reg || slot_free)
                begin
                    if (held_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_band_next  = held_band_reg;
                        out_bar_next   = held_bar_reg;
                        out_final_next = held_final_reg;
                        out_end_next   = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_band_next  = open_band_reg[7:0];
                    held_bar_next   = quo_reg;
                    held_final_next = ({1'b0, open_band_reg} + 10'd1)
                                      == {1'b0, BAND_TOTAL};
                    open_band_next  = open_band_reg + 9'd1;
                    sum_next        = '0;
                    cnt_next        = '0;
                    nres_next       = nres_reg + 7'd1;
                    state_next      = ST_BAND;
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_band_next   = held_band_reg;
                    out_bar_next    = held_bar_reg;
                    out_final_next  = held_final_reg;
                    out_end_next    = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bin_ch.ready |-> !held_valid_reg)
        else $error("bin taken while a result is still staged");

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        open_band_reg <= BAND_TOTAL)
        else $error("open band ran past the band total");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MULT |-> cnt_reg != 12'd0)
        else $error("band closed with zero bins");

    a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= 7'(MAX_RES))
        else $error("too many results for one bin");

    a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && slot_free) |=> (out_valid_reg && out_end_reg))
        else $error("run end not marked on flushed result");

endmodule

>>> test/lbsa_band_checker.sv
`timescale 1ns / 100ps
// Band checker: watches the bin and band channels, predicts every band result
// and compares it field by field. Depends on lbsa_pkg and lbsa_chan_if.
module lbsa_band_checker (
    input  logic  clk,
    input  logic  rst_n,
    lbsa_bin_if   bin_mon,
    lbsa_band_if  band_mon,
    output int    errors,
    output int    pending
);
    import lbsa_pkg::*;

    localparam int HALF     = FFT_SIZE_DEF / 2;
    localparam int HALF_LOG = $clog2(FFT_SIZE_DEF / 2);
    localparam int SHIFT    = $clog2(FFT_SIZE_DEF);
    localparam int PW       = 2400;

    typedef struct packed {
        logic [7:0]  band_number;
        logic [11:0] bar_height;
        logic        final_band;
        logic        run_end;
    } band_res_t;

    // band bounds, own derivation with exact integer roots
    logic [11:0] band_lo [0:BAND_MAX-1];
    logic [11:0] band_hi [0:BAND_MAX-1];
    int          band_count;

    // predictor state
    logic [11:0] next_bin;
    int          cur_band;
    logic [31:0] band_sum;
    logic [11:0] band_bins;

    band_res_t   expected_bands [$];

    function automatic logic [PW-1:0] pow_steps(int unsigned b);
        logic [PW-1:0] p;
        p = PW'(b);
        for (int i = 0; i < $clog2(BAND_STEPS_DEF); i++)
            p = p * p;
        return p;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag_of(logic signed [31:0] v);
        logic [63:0] a;
        a = v[31] ? 64'(-65'(v)) : 64'(v);
        return a;
    endfunction

    // derive the band table once
    initial
    begin
        int unsigned rf [0:BAND_STEPS_DEF];
        bit          rx [0:BAND_STEPS_DEF];
        int unsigned b;
        logic [PW-1:0] lim;
        b = 1;
        for (int k = 0; k <= BAND_STEPS_DEF; k++)
        begin
            lim = '0;
            lim[HALF_LOG * k] = 1'b1;
            while (pow_steps(b + 1) <= lim)
                b++;
            rf[k] = b;
            rx[k] = (pow_steps(b) == lim);
        end
        band_count = 0;
        for (int k = 0; k < BAND_STEPS_DEF && k < BAND_MAX; k++)
        begin
            band_lo[k] = 0;
            band_hi[k] = 0;
        end
        for (int k = 0; k < BAND_STEPS_DEF && k < BAND_MAX; k++)
        begin
            if (rf[k + 1] >= HALF - 1)
                break;
            band_lo[k] = 12'(rf[k]);
            band_hi[k] = rx[k + 1] ? 12'(rf[k + 1] - 1) : 12'(rf[k + 1]);
            band_count = k + 1;
        end
    end

    // predict the bands that one bin closes
    task automatic predict_bands(logic signed [31:0] re, logic signed [31:0] im,
                                 logic fs);
        logic [11:0] b;
        logic [63:0] ar;
        logic [63:0] ai;
        logic [63:0] mag;
        logic [63:0] total;
        logic [63:0] bar;
        band_res_t   res;
        int          n;
        n = 0;
        if (fs)
        begin
            next_bin  = '0;
            cur_band  = 0;
            band_sum  = '0;
            band_bins = '0;
        end
        b = next_bin;
        if (next_bin != 12'hFFF)
            next_bin = next_bin + 12'd1;
        ar  = mag_of(re);
        ai  = mag_of(im);
        mag = int_root(ar * ar + ai * ai) >> SHIFT;
        while (cur_band < band_count && n < MAX_RES)
        begin
            if (b < band_lo[cur_band])
                break;
            total    = 64'(band_sum) + mag;
            band_sum = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
            if (band_bins != 12'hFFF)
                band_bins = band_bins + 12'd1;
            if (b < band_hi[cur_band])
                break;
            bar = (64'(band_sum) * 2000) / (64'(band_bins) * 32768);
            res.band_number = 8'(cur_band);
            res.bar_height  = (bar > 4095) ? 12'hFFF : bar[11:0];
            res.final_band  = (cur_band + 1 == band_count);
            res.run_end     = 1'b0;
            expected_bands.push_back(res);
            n++;
            cur_band++;
            band_sum  = '0;
            band_bins = '0;
        end
        if (n > 0)
            expected_bands[$].run_end = 1'b1;
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        band_res_t want;
        if (!rst_n)
        begin
            next_bin  = '0;
            cur_band  = 0;
            band_sum  = '0;
            band_bins = '0;
            errors    <= 0;
            expected_bands.delete();
        end
        else
        begin
            if (bin_mon.valid && bin_mon.ready)
                predict_bands(bin_mon.bin_real, bin_mon.bin_imag, bin_mon.frame_start);
            if (band_mon.valid && band_mon.ready)
            begin
                if (expected_bands.size() == 0)
                begin
                    $display("%0t: unexpected band transfer: band %0d height %0d",
                             $time, band_mon.band_number, band_mon.bar_height);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_bands.pop_front();
                    if (band_mon.band_number !== want.band_number ||
                        band_mon.bar_height  !== want.bar_height  ||
                        band_mon.final_band  !== want.final_band  ||
                        band_mon.run_end     !== want.run_end)
                    begin
                        $display("%0t: band mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 $time, want.band_number, want.bar_height,
                                 want.final_band, want.run_end,
                                 band_mon.band_number, band_mon.bar_height,
                                 band_mon.final_band, band_mon.run_end);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    assign pending = expected_bands.size();

endmodule

>>> test/log_band_spectrum_averager_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the log-band spectrum averager: clock, reset, bin stimulus,
// output back-pressure and verdict. Depends on lbsa_chan_if, the averager unit, checker.
module log_band_spectrum_averager_unit_tb;

    localparam int CYCLE_LIMIT = 20000000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    int   bands_taken;

    lbsa_bin_if  bin_ch ();
    lbsa_band_if band_ch ();

    log_band_spectrum_averager_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bin_ch  (bin_ch),
        .band_ch (band_ch)
    );

    lbsa_band_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .bin_mon  (bin_ch),
        .band_mon (band_ch),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // random bin part with a wide spread of magnitudes
    function automatic logic signed [31:0] rand_part();
        logic [31:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic send_bin(logic signed [31:0] re, logic signed [31:0] im,
                            logic fs, bit idle);
        int g;
        bin_ch.valid       <= 1'b1;
        bin_ch.bin_real    <= re;
        bin_ch.bin_imag    <= im;
        bin_ch.frame_start <= fs;
        @(posedge clk);
        while (!bin_ch.ready)
            @(posedge clk);
        g = idle ? gap_len() : 0;
        if (g > 0)
        begin
            bin_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // output side: random stalls plus one long hold-off
    initial
    begin
        int  hold;
        bit  held;
        band_ch.ready = 1'b0;
        bands_taken   = 0;
        held          = 1'b0;
        hold          = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (band_ch.valid && band_ch.ready)
                bands_taken++;
            if (!held && bands_taken >= 150)
            begin
                held = 1'b1;
                hold = 4000;
            end
            if (hold > 0)
            begin
                hold--;
                band_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                hold = $urandom_range(20, 150);
                band_ch.ready <= 1'b0;
            end
            else
                band_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // bin stimulus
    initial
    begin
        int n;
        bin_ch.valid       = 1'b0;
        bin_ch.bin_real    = 0;
        bin_ch.bin_imag    = 0;
        bin_ch.frame_start = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, a bin closing many bands, restart mid-frame
        send_bin(32'sd0, 32'sd0, 1'b1, 1'b0);
        send_bin(-32'sh8000_0000, -32'sh8000_0000, 1'b0, 1'b0);
        send_bin(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
        send_bin(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b0, 1'b0);
        send_bin(-32'sd1, 32'sd0, 1'b0, 1'b0);
        send_bin(32'sd0, 32'sd1, 1'b0, 1'b0);
        send_bin(32'sd1024, -32'sd1024, 1'b0, 1'b0);
        send_bin(32'sd17000, 32'sd0, 1'b0, 1'b0);
        send_bin(32'sd0, 32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_bin(32'sd0, 32'sd0, 1'b0, 1'b0);
        send_bin(32'sd16384, 32'sd0, 1'b0, 1'b0);
        for (int i = 0; i < 12; i++)
            send_bin(rand_part(), rand_part(), 1'b0, 1'b0);

        // random short frames
        for (int f = 0; f < 4; f++)
        begin
            n = $urandom_range(10, 30);
            for (int i = 0; i < n; i++)
                send_bin(rand_part(), rand_part(), i == 0, 1'b1);
        end

        // one longer frame reaching the upper bands
        for (int i = 0; i < 150; i++)
            send_bin(rand_part(), rand_part(), i == 0, 1'b1);

        // a few short frames more
        for (int f = 0; f < 2; f++)
        begin
            n = $urandom_range(10, 20);
            for (int i = 0; i < n; i++)
                send_bin(rand_part(), rand_part(), i == 0, 1'b1);
        end
        bin_ch.valid <= 1'b0;

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lbsa_pkg.sv
rtl/lbsa_chan_if.sv
rtl/lbsa_mag_unit.sv
rtl/log_band_spectrum_averager_unit.sv
test/lbsa_band_checker.sv
test/log_band_spectrum_averager_unit_tb.sv
